### rtl/core/hpvc_pkg.sv
`timescale 1ns / 1ps
// Package for the hand pump volume controller: modes, actions, register
// indexes, reset values and the structs passed between its modules.
// No dependencies.
package hpvc_pkg;

  localparam int unsigned DistW   = 17;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned AreaW   = 12;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned VolumeW = 28;
  localparam int unsigned HeightW = DistW + 1;
  localparam int unsigned ProdW   = DistW + AreaW;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LevelW-1:0]  HandOnLevelRst     = 16'd1500;
  localparam logic [LevelW-1:0]  HandOffLevelRst    = 16'd2200;
  localparam logic [LevelW-1:0]  HandOffTimeoutRst  = 16'd500;
  localparam logic [LevelW-1:0]  CriticalLevelRst   = 16'd2000;
  localparam logic [AreaW-1:0]   TankAreaRst        = 12'd300;
  localparam logic [LevelW-1:0]  SettleMinRst       = 16'd1000;
  localparam logic [LevelW-1:0]  SettleMaxRst       = 16'd5000;
  localparam logic [LevelW-1:0]  MinDropRst         = 16'd30;

  localparam logic [TimeW-1:0]   CalcHoldMs = 32'd1000;
  localparam logic [TimeW-1:0]   ShowHoldMs = 32'd3000;
  localparam logic [ProdW-1:0]   VolumeMax  = 29'd268431360;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_PUMPING     = 3'd1,
    MODE_STABILIZING = 3'd2,
    MODE_CALCULATING = 3'd3,
    MODE_SHOW        = 3'd4,
    MODE_CRITICAL    = 3'd5,
    MODE_REFILL      = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_DISPENSED = 2'd1,
    ACT_ADDED     = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HAND_ON_LEVEL  = 3'd0,
    CFG_HAND_OFF_LEVEL = 3'd1,
    CFG_HAND_OFF_TMO   = 3'd2,
    CFG_CRITICAL_LEVEL = 3'd3,
    CFG_TANK_AREA      = 3'd4,
    CFG_SETTLE_MIN     = 3'd5,
    CFG_SETTLE_MAX     = 3'd6,
    CFG_MIN_DROP       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] hand_on_level;
    logic [LevelW-1:0] hand_off_level;
    logic [LevelW-1:0] away_timeout_ms;
    logic [LevelW-1:0] critical_level;
    logic [AreaW-1:0]  tank_area;
    logic [LevelW-1:0] settle_min_ms;
    logic [LevelW-1:0] settle_max_ms;
    logic [LevelW-1:0] min_drop;
  } cfg_t;

  typedef struct packed {
    logic signed [DistW-1:0] hand_distance;
    logic signed [DistW-1:0] water_distance;
    logic                    touch_pressed;
    logic                    water_settled;
    logic [TimeW-1:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic               pump_on;
    mode_e              mode;
    logic [VolumeW-1:0] volume;
    logic               is_dispense;
  } result_t;

endpackage

### rtl/core/hpvc_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the hand pump volume controller.
// Depends on hpvc_pkg for register indexes, reset values and cfg_t.
module hpvc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hpvc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hpvc_pkg::LevelW-1:0]    cfg_data_i,
  output hpvc_pkg::cfg_t                 cfg_o
);
  import hpvc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hand_on_level       <= HandOnLevelRst;
      cfg_q.hand_off_level      <= HandOffLevelRst;
      cfg_q.away_timeout_ms     <= HandOffTimeoutRst;
      cfg_q.critical_level      <= CriticalLevelRst;
      cfg_q.tank_area           <= TankAreaRst;
      cfg_q.settle_min_ms       <= SettleMinRst;
      cfg_q.settle_max_ms       <= SettleMaxRst;
      cfg_q.min_drop            <= MinDropRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HAND_ON_LEVEL:  cfg_q.hand_on_level       <= cfg_data_i;
        CFG_HAND_OFF_LEVEL: cfg_q.hand_off_level      <= cfg_data_i;
        CFG_HAND_OFF_TMO:   cfg_q.away_timeout_ms     <= cfg_data_i;
        CFG_CRITICAL_LEVEL: cfg_q.critical_level      <= cfg_data_i;
        CFG_TANK_AREA:      cfg_q.tank_area           <= cfg_data_i[AreaW-1:0];
        CFG_SETTLE_MIN:     cfg_q.settle_min_ms       <= cfg_data_i;
        CFG_SETTLE_MAX:     cfg_q.settle_max_ms       <= cfg_data_i;
        CFG_MIN_DROP:       cfg_q.min_drop            <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/hpvc_volume.sv
`timescale 1ns / 1ps
// Volume calculation: height change of the water surface times tank area,
// with the dispense threshold and the upper clamp. Depends on hpvc_pkg.
module hpvc_volume (
  input  hpvc_pkg::action_e                   action_i,
  input  logic signed [hpvc_pkg::DistW-1:0]   water_i,
  input  logic signed [hpvc_pkg::DistW-1:0]   start_water_i,
  input  logic [hpvc_pkg::LevelW-1:0]         min_drop_i,
  input  logic [hpvc_pkg::AreaW-1:0]          tank_area_i,
  output logic [hpvc_pkg::VolumeW-1:0]        volume_o
);
  import hpvc_pkg::*;

  logic signed [HeightW-1:0] h_disp;
  logic signed [HeightW-1:0] h_add;
  logic signed [HeightW-1:0] h_sel;
  logic                      disp_ok;
  logic [ProdW-1:0]          prod;

  assign h_disp  = HeightW'(water_i) - HeightW'(start_water_i);
  assign h_add   = HeightW'(start_water_i) - HeightW'(water_i);
  assign disp_ok = h_disp >= $signed({2'b00, min_drop_i});

  always_comb begin
    h_sel = '0;
    if (action_i == ACT_DISPENSED) begin
      if (disp_ok) begin
        h_sel = h_disp;
      end
    end else if (!h_add[HeightW-1]) begin
      h_sel = h_add;
    end
  end

  // The selected height is never negative, so its low bits are its magnitude.
  assign prod = ProdW'(h_sel[DistW-1:0]) * ProdW'(tank_area_i);

  assign volume_o = (prod > VolumeMax) ? VolumeMax[VolumeW-1:0] : prod[VolumeW-1:0];

endmodule

### rtl/core/hpvc_ctrl.sv
`timescale 1ns / 1ps
// Mode machine of the hand pump volume controller: pump hysteresis, absence
// timer, settle wait and refill. Depends on hpvc_pkg and hpvc_volume.
module hpvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  hpvc_pkg::item_t   item_i,
  input  hpvc_pkg::cfg_t    cfg_i,
  output hpvc_pkg::result_t result_o
);
  import hpvc_pkg::*;

  mode_e                    mode_q, mode_d;
  logic                     pump_q, pump_d;
  logic                     prev_touch_q;
  logic signed [DistW-1:0]  start_water_q, start_water_d;
  logic [VolumeW-1:0]       last_result_q, last_result_d;
  logic [TimeW-1:0]         mark_time_q, mark_time_d;
  logic [TimeW-1:0]         away_since_q, away_since_d;
  logic                     away_valid_q, away_valid_d;
  action_e                  action_q, action_d;

  logic                     rising;
  logic                     hand_seen;
  logic                     hand_away;
  logic                     critical;
  logic [TimeW-1:0]         away_el;
  logic [TimeW-1:0]         mark_el;
  logic [VolumeW-1:0]       volume;

  assign rising    = item_i.touch_pressed && !prev_touch_q;
  assign hand_seen = (item_i.hand_distance > 0) &&
                     (item_i.hand_distance < $signed({1'b0, cfg_i.hand_on_level}));
  assign hand_away = (item_i.hand_distance > $signed({1'b0, cfg_i.hand_off_level})) ||
                     item_i.hand_distance[DistW-1];
  assign critical  = (item_i.water_distance > $signed({1'b0, cfg_i.critical_level})) ||
                     (item_i.water_distance <= 0);
  assign away_el   = item_i.now_ms - away_since_q;
  assign mark_el   = item_i.now_ms - mark_time_q;

  hpvc_volume u_volume (
    .action_i      (action_q),
    .water_i       (item_i.water_distance),
    .start_water_i (start_water_q),
    .min_drop_i    (cfg_i.min_drop),
    .tank_area_i   (cfg_i.tank_area),
    .volume_o      (volume)
  );

  always_comb begin
    mode_d        = mode_q;
    pump_d        = pump_q;
    start_water_d = start_water_q;
    last_result_d = last_result_q;
    mark_time_d   = mark_time_q;
    away_since_d  = away_since_q;
    away_valid_d  = away_valid_q;
    action_d      = action_q;
    case (mode_q)
      MODE_IDLE: begin
        pump_d = 1'b0;
        if (critical || rising) begin
          start_water_d = item_i.water_distance;
          mode_d        = MODE_REFILL;
        end else if (hand_seen) begin
          start_water_d = item_i.water_distance;
          pump_d        = 1'b1;
          mode_d        = MODE_PUMPING;
        end
      end
      MODE_PUMPING: begin
        if (critical) begin
          pump_d        = 1'b0;
          start_water_d = item_i.water_distance;
          mode_d        = MODE_REFILL;
        end else if (hand_away) begin
          if (!away_valid_q) begin
            away_since_d = item_i.now_ms;
            away_valid_d = 1'b1;
          end else if (away_el > TimeW'(cfg_i.away_timeout_ms)) begin
            pump_d       = 1'b0;
            mark_time_d  = item_i.now_ms;
            action_d     = ACT_DISPENSED;
            away_valid_d = 1'b0;
            mode_d       = MODE_STABILIZING;
          end
        end else begin
          away_valid_d = 1'b0;
        end
      end
      MODE_STABILIZING: begin
        if (hand_seen) begin
          pump_d = 1'b1;
          mode_d = MODE_PUMPING;
        end else if ((mark_el >= TimeW'(cfg_i.settle_min_ms)) &&
                     (item_i.water_settled || (mark_el >= TimeW'(cfg_i.settle_max_ms)))) begin
          last_result_d = volume;
          mark_time_d   = item_i.now_ms;
          mode_d        = MODE_CALCULATING;
        end
      end
      MODE_CALCULATING: begin
        if (hand_seen) begin
          pump_d = 1'b1;
          mode_d = MODE_PUMPING;
        end else if (mark_el > CalcHoldMs) begin
          mark_time_d = item_i.now_ms;
          mode_d      = MODE_SHOW;
        end
      end
      MODE_SHOW: begin
        if (hand_seen) begin
          pump_d = 1'b1;
          mode_d = MODE_PUMPING;
        end else if (mark_el > ShowHoldMs) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_REFILL: begin
        pump_d = 1'b0;
        if (rising && !critical) begin
          mark_time_d = item_i.now_ms;
          action_d    = ACT_ADDED;
          mode_d      = MODE_STABILIZING;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      pump_q        <= 1'b0;
      prev_touch_q  <= 1'b0;
      start_water_q <= '0;
      last_result_q <= '0;
      mark_time_q   <= '0;
      away_since_q  <= '0;
      away_valid_q  <= 1'b0;
      action_q      <= ACT_NONE;
    end else if (step_i) begin
      mode_q        <= mode_d;
      pump_q        <= pump_d;
      prev_touch_q  <= item_i.touch_pressed;
      start_water_q <= start_water_d;
      last_result_q <= last_result_d;
      mark_time_q   <= mark_time_d;
      away_since_q  <= away_since_d;
      away_valid_q  <= away_valid_d;
      action_q      <= action_d;
    end
  end

  assign result_o.pump_on     = pump_d;
  assign result_o.mode        = mode_d;
  assign result_o.volume      = last_result_d;
  assign result_o.is_dispense = (action_d == ACT_DISPENSED);

endmodule

### rtl/core/hand_pump_volume_controller_unit.sv
`timescale 1ns / 1ps
// Hand pump volume controller, top level. One input transaction is one
// control tick: hand distance, water distance, touch level, surface-stable
// flag and a millisecond timestamp. Every tick yields exactly one output
// transaction with the pump drive, the mode code, the last measured volume
// and whether it was a dispense.
// An accepted tick is held in an input register; the mode machine and the
// volume multiplier evaluate it and, once the output register is free, the
// result is written to the output register and out_valid_o rises. One tick
// is accepted every cycle while the output side takes results; the rate is
// set by the update of the mode state. When the receiver asserts out_stall_i
// the output holds its transaction; the input register still accepts one
// more tick, after which in_stall_o rises until the output is taken. The
// controller state only advances when a tick moves into the output register,
// so nothing is lost or repeated. Reset empties both registers, returns to
// idle with the pump off and loads the configuration defaults. Configuration
// registers are written through cfg_we_i, cfg_index_i and cfg_data_i; the
// user must write them only while no tick is in flight, as the block itself
// does not enforce it.
module hand_pump_volume_controller_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hpvc_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [hpvc_pkg::LevelW-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [hpvc_pkg::DistW-1:0]     hand_distance_i,
  input  logic signed [hpvc_pkg::DistW-1:0]     water_distance_i,
  input  logic                                  touch_pressed_i,
  input  logic                                  water_settled_i,
  input  logic [hpvc_pkg::TimeW-1:0]            now_ms_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  pump_on_o,
  output logic [2:0]                            mode_code_o,
  output logic [hpvc_pkg::VolumeW-1:0]          result_volume_o,
  output logic                                  result_dispensed_o
);
  import hpvc_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s1_item_q;
  logic    s1_valid_q, s1_valid_d;
  result_t next_res;
  result_t out_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    accept;

  hpvc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_item.hand_distance  = hand_distance_i;
  assign in_item.water_distance = water_distance_i;
  assign in_item.touch_pressed  = touch_pressed_i;
  assign in_item.water_settled  = water_settled_i;
  assign in_item.now_ms         = now_ms_i;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item;
    end
    if (advance) begin
      out_q <= next_res;
    end
  end

  hpvc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (next_res)
  );

  assign out_valid_o          = out_valid_q;
  assign pump_on_o            = out_q.pump_on;
  assign mode_code_o          = out_q.mode;
  assign result_volume_o      = out_q.volume;
  assign result_dispensed_o   = out_q.is_dispense;

`ifndef NO_ASSERTIONS
  a_pump_only_when_pumping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pump_on_o == (mode_code_o == MODE_PUMPING)))
    else $error("pump drive disagrees with the reported mode");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output side can move");

  a_new_result_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("a processed tick did not produce an output transaction");
`endif

endmodule
